/* rtl/core/adm_pkg.sv */
`timescale 1ns / 1ps
// shared widths, register codes and pipeline payload types of the drive mixer
package adm_pkg;

    localparam int CMD_W      = 18;  // raw command, Q2.15
    localparam int CLP_W      = 17;  // clamped command, [-1, 1] in Q.15
    localparam int CFG_W      = 16;  // Q8.8 gains and limit
    localparam int PRD_W      = 33;  // clamped command times one gain
    localparam int T_SHIFT    = 9;   // throttle term lines up with Q.32
    localparam int TRN_W      = PRD_W + T_SHIFT;
    localparam int SUM_W      = 49;  // signed left / right in Q.32
    localparam int MAG_W      = 48;  // their magnitudes
    localparam int HALF_W     = MAG_W / 2;
    localparam int PROD_W     = MAG_W + CFG_W;
    localparam int K_SHIFT    = 8;   // scale target is throttle_limit * 256
    localparam int QUO_W      = CFG_W + K_SHIFT;
    localparam int LIM_SHIFT  = 24;  // output limit is throttle_limit << 24
    localparam int FRAC_SHIFT = 16;  // Q.32 down to Q16.16
    localparam int OUT_W      = 32;
    localparam int ADDR_W     = 4;
    localparam int ADDR_LSB   = 2;
    localparam int DATA_W     = 32;
    localparam int MIX_STAGES = 7;
    localparam int LATENCY    = MIX_STAGES + QUO_W + 1;

    localparam logic [CFG_W-1:0]        LIMIT_RESET = 16'd256;
    localparam logic signed [CMD_W-1:0] CMD_POS_ONE = 18'sd32768;
    localparam logic signed [CMD_W-1:0] CMD_NEG_ONE = -18'sd32768;
    localparam logic [OUT_W-1:0]        SAT_MAX     = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]        SAT_MIN     = 32'h8000_0000;

    typedef enum logic [1:0] {
        REG_THROTTLE_LIMIT = 2'd0,
        REG_TURN_LIMIT     = 2'd1,
        REG_TRACK_WIDTH    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] throttle_limit;
        logic [CFG_W-1:0] turn_limit;
        logic [CFG_W-1:0] track_width;
    } t_cfg;

    typedef struct packed {
        logic             neg_l;
        logic             neg_r;
        logic             scaled;
        logic             left_min;
        logic [OUT_W-1:0] unsc_l;
        logic [OUT_W-1:0] unsc_r;
    } t_side;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [MAG_W-1:0] peak;
        t_side            side;
    } t_div;

endpackage

/* rtl/core/adm_cfg_regs.sv */
`timescale 1ns / 1ps
// apb register file holding the three gain and limit settings
module adm_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adm_pkg::ADDR_W-1:0]   paddr,
    input  logic [adm_pkg::DATA_W-1:0]   pwdata,
    output logic [adm_pkg::DATA_W-1:0]   prdata,
    output adm_pkg::t_cfg                o_cfg
);

    logic                        w_wr;
    logic [1:0]                  w_idx;
    logic [adm_pkg::CFG_W-1:0]   r_throttle_limit, n_throttle_limit;
    logic [adm_pkg::CFG_W-1:0]   r_turn_limit, n_turn_limit;
    logic [adm_pkg::CFG_W-1:0]   r_track_width, n_track_width;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[adm_pkg::ADDR_W-1:adm_pkg::ADDR_LSB];

    always_comb begin
        n_throttle_limit = r_throttle_limit;
        n_turn_limit     = r_turn_limit;
        n_track_width    = r_track_width;
        if (w_wr) begin
            case (w_idx)
                adm_pkg::REG_THROTTLE_LIMIT: n_throttle_limit = pwdata[adm_pkg::CFG_W-1:0];
                adm_pkg::REG_TURN_LIMIT:     n_turn_limit     = pwdata[adm_pkg::CFG_W-1:0];
                adm_pkg::REG_TRACK_WIDTH:    n_track_width    = pwdata[adm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle_limit <= adm_pkg::LIMIT_RESET;
            r_turn_limit     <= adm_pkg::LIMIT_RESET;
            r_track_width    <= adm_pkg::LIMIT_RESET;
        end else begin
            r_throttle_limit <= n_throttle_limit;
            r_turn_limit     <= n_turn_limit;
            r_track_width    <= n_track_width;
        end
    end

    always_comb begin
        case (w_idx)
            adm_pkg::REG_THROTTLE_LIMIT:
                prdata = {{(adm_pkg::DATA_W-adm_pkg::CFG_W){1'b0}}, r_throttle_limit};
            adm_pkg::REG_TURN_LIMIT:
                prdata = {{(adm_pkg::DATA_W-adm_pkg::CFG_W){1'b0}}, r_turn_limit};
            adm_pkg::REG_TRACK_WIDTH:
                prdata = {{(adm_pkg::DATA_W-adm_pkg::CFG_W){1'b0}}, r_track_width};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.throttle_limit = r_throttle_limit;
    assign o_cfg.turn_limit     = r_turn_limit;
    assign o_cfg.track_width    = r_track_width;

endmodule

/* rtl/core/adm_mix.sv */
`timescale 1ns / 1ps
// front pipeline: clamp, gains, left/right sums, peak pick and divider setup
module adm_mix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [adm_pkg::CMD_W-1:0]  i_throttle_cmd,
    input  logic signed [adm_pkg::CMD_W-1:0]  i_turn_cmd,
    input  adm_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output adm_pkg::t_div                     o_div
);

    localparam int SP_W = adm_pkg::PRD_W + adm_pkg::CLP_W;
    localparam int LP_W = adm_pkg::HALF_W + adm_pkg::CFG_W;

    // Q.32 magnitude to saturated Q16.16 field
    function automatic logic [adm_pkg::OUT_W-1:0] sat_field(
        input logic                      neg,
        input logic [adm_pkg::MAG_W-1:0] mag
    );
        logic [adm_pkg::OUT_W-1:0] upper;
        upper = mag[adm_pkg::MAG_W-1:adm_pkg::FRAC_SHIFT];
        if (neg) begin
            sat_field = (upper > adm_pkg::SAT_MIN) ? adm_pkg::SAT_MIN
                                                   : adm_pkg::OUT_W'(0) - upper;
        end else begin
            sat_field = (upper > adm_pkg::SAT_MAX) ? adm_pkg::SAT_MAX : upper;
        end
    endfunction

    // valid chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    // stage 1: clamp and first gains
    logic signed [adm_pkg::CLP_W-1:0]   w_ct, w_cr;
    logic signed [2*adm_pkg::CLP_W-1:0] w_pt_full, w_pr_full;
    logic signed [adm_pkg::PRD_W-1:0]   r_pt, r_pr;

    // stage 2: track width on the turn term
    logic signed [SP_W-1:0]             w_s_full;
    logic [adm_pkg::TRN_W-1:0]          r_t;
    logic [adm_pkg::SUM_W-1:0]          r_s;

    // stage 3: sums
    logic [adm_pkg::SUM_W-1:0]          w_t_ext;
    logic [adm_pkg::SUM_W-1:0]          r_left, r_right;

    // stage 4: magnitudes
    logic [adm_pkg::SUM_W-1:0]          w_abs_l, w_abs_r;
    logic [adm_pkg::MAG_W-1:0]          r_ml, r_mr;
    logic                               r_neg_l4, r_neg_r4;

    // stage 5: peak and smaller side
    logic                               w_left_min;
    logic [adm_pkg::MAG_W-1:0]          r_peak5, r_mnr;
    adm_pkg::t_side                     r_side5;

    // stage 6: limit compare and split products
    logic [adm_pkg::MAG_W-1:0]          w_lim;
    logic [LP_W-1:0]                    r_plo, r_phi;
    logic [adm_pkg::MAG_W-1:0]          r_peak6;
    adm_pkg::t_side                     r_side6;

    // stage 7: numerator assembly
    logic [adm_pkg::PROD_W-1:0]         w_prod;
    adm_pkg::t_div                      r_div;

    always_comb begin
        if (i_throttle_cmd > adm_pkg::CMD_POS_ONE) begin
            w_ct = adm_pkg::CMD_POS_ONE[adm_pkg::CLP_W-1:0];
        end else if (i_throttle_cmd < adm_pkg::CMD_NEG_ONE) begin
            w_ct = adm_pkg::CMD_NEG_ONE[adm_pkg::CLP_W-1:0];
        end else begin
            w_ct = i_throttle_cmd[adm_pkg::CLP_W-1:0];
        end
        if (i_turn_cmd > adm_pkg::CMD_POS_ONE) begin
            w_cr = adm_pkg::CMD_POS_ONE[adm_pkg::CLP_W-1:0];
        end else if (i_turn_cmd < adm_pkg::CMD_NEG_ONE) begin
            w_cr = adm_pkg::CMD_NEG_ONE[adm_pkg::CLP_W-1:0];
        end else begin
            w_cr = i_turn_cmd[adm_pkg::CLP_W-1:0];
        end
    end

    assign w_pt_full = w_ct * $signed({1'b0, i_cfg.throttle_limit});
    assign w_pr_full = w_cr * $signed({1'b0, i_cfg.turn_limit});

    assign w_s_full = r_pr * $signed({1'b0, i_cfg.track_width});

    assign w_t_ext = {{(adm_pkg::SUM_W-adm_pkg::TRN_W){r_t[adm_pkg::TRN_W-1]}}, r_t};

    assign w_abs_l = r_left[adm_pkg::SUM_W-1]  ? adm_pkg::SUM_W'(0) - r_left  : r_left;
    assign w_abs_r = r_right[adm_pkg::SUM_W-1] ? adm_pkg::SUM_W'(0) - r_right : r_right;

    assign w_left_min = (r_ml <= r_mr);

    assign w_lim = {{(adm_pkg::MAG_W-adm_pkg::CFG_W-adm_pkg::LIM_SHIFT){1'b0}},
                    i_cfg.throttle_limit, {adm_pkg::LIM_SHIFT{1'b0}}};

    assign w_prod = {r_phi, {adm_pkg::HALF_W{1'b0}}}
                  + {{adm_pkg::HALF_W{1'b0}}, r_plo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt <= w_pt_full[adm_pkg::PRD_W-1:0];
        r_pr <= w_pr_full[adm_pkg::PRD_W-1:0];

        r_t <= {r_pt, {adm_pkg::T_SHIFT{1'b0}}};
        r_s <= w_s_full[adm_pkg::SUM_W-1:0];

        r_left  <= w_t_ext - r_s;
        r_right <= w_t_ext + r_s;

        r_ml     <= w_abs_l[adm_pkg::MAG_W-1:0];
        r_mr     <= w_abs_r[adm_pkg::MAG_W-1:0];
        r_neg_l4 <= r_left[adm_pkg::SUM_W-1];
        r_neg_r4 <= r_right[adm_pkg::SUM_W-1];

        r_peak5          <= w_left_min ? r_mr : r_ml;
        r_mnr            <= w_left_min ? r_ml : r_mr;
        r_side5.neg_l    <= r_neg_l4;
        r_side5.neg_r    <= r_neg_r4;
        r_side5.scaled   <= 1'b0;
        r_side5.left_min <= w_left_min;
        r_side5.unsc_l   <= sat_field(r_neg_l4, r_ml);
        r_side5.unsc_r   <= sat_field(r_neg_r4, r_mr);

        r_plo            <= r_mnr[adm_pkg::HALF_W-1:0] * i_cfg.throttle_limit;
        r_phi            <= r_mnr[adm_pkg::MAG_W-1:adm_pkg::HALF_W] * i_cfg.throttle_limit;
        r_peak6          <= r_peak5;
        r_side6.neg_l    <= r_side5.neg_l;
        r_side6.neg_r    <= r_side5.neg_r;
        r_side6.scaled   <= (r_peak5 > w_lim);
        r_side6.left_min <= r_side5.left_min;
        r_side6.unsc_l   <= r_side5.unsc_l;
        r_side6.unsc_r   <= r_side5.unsc_r;

        // numerator is w_prod << 8; top bits seed the remainder, the rest shift in
        r_div.rem  <= w_prod[adm_pkg::PROD_W-1:adm_pkg::QUO_W-adm_pkg::K_SHIFT];
        r_div.low  <= {w_prod[adm_pkg::QUO_W-adm_pkg::K_SHIFT-1:0], {adm_pkg::K_SHIFT{1'b0}}};
        r_div.quo  <= '0;
        r_div.peak <= r_peak6;
        r_div.side <= r_side6;
    end

    assign o_valid = r_v7;
    assign o_div   = r_div;

endmodule

/* rtl/core/adm_div_step.sv */
`timescale 1ns / 1ps
// one registered restoring-division step: one quotient bit per stage
module adm_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  adm_pkg::t_div i_div,
    output logic          o_valid,
    output adm_pkg::t_div o_div
);

    logic [adm_pkg::MAG_W:0] w_trial, w_diff;
    logic                    w_take;
    adm_pkg::t_div           n_div, r_div;
    logic                    r_valid;

    assign w_trial = {i_div.rem, i_div.low[adm_pkg::QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, i_div.peak};
    assign w_take  = (w_trial >= {1'b0, i_div.peak});

    always_comb begin
        n_div      = i_div;
        n_div.rem  = w_take ? w_diff[adm_pkg::MAG_W-1:0] : w_trial[adm_pkg::MAG_W-1:0];
        n_div.low  = {i_div.low[adm_pkg::QUO_W-2:0], 1'b0};
        n_div.quo  = {i_div.quo[adm_pkg::QUO_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

/* rtl/core/arcade_drive_mixer_unit.sv */
`timescale 1ns / 1ps
// top level of the arcade drive mixer: config port, mix pipeline, divider chain, output
//
// usage
//   request channel: drive i_throttle_cmd / i_turn_cmd and pulse start; a request is
//   taken at every rising edge with start high and busy low. busy is low whenever
//   reset is released, so a new request can enter every cycle (one per clock).
//   result channel: o_valid is high for exactly one cycle with o_left_drive,
//   o_right_drive and o_was_scaled; results come out in request order.
//   pipeline: 7 front stages, 24 divider stages of one quotient bit each and 1 output
//   stage lie between the accepting edge and the edge that takes the result.
//   the divider chain sets the depth; a front stage can hold two multipliers or two
//   wide adds side by side, and each divider stage holds one wide subtract/compare.
//   the receiver cannot stall: results are never held back, the pipeline never stops.
//   config: apb writes at byte address 0 (throttle_limit), 4 (turn_limit),
//   8 (track_width); pready is always high, reads return the register value.
//   change config only with the pipeline empty.
//   reset (synchronous, active low) empties the pipeline, raises busy and
//   sets every config register to 1.0 (256 in Q8.8).
module arcade_drive_mixer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [adm_pkg::CMD_W-1:0]    i_throttle_cmd,
    input  logic signed [adm_pkg::CMD_W-1:0]    i_turn_cmd,
    output logic                                o_valid,
    output logic signed [adm_pkg::OUT_W-1:0]    o_left_drive,
    output logic signed [adm_pkg::OUT_W-1:0]    o_right_drive,
    output logic                                o_was_scaled,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adm_pkg::ADDR_W-1:0]          paddr,
    input  logic [adm_pkg::DATA_W-1:0]          pwdata,
    output logic [adm_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    adm_pkg::t_cfg              w_cfg;
    logic                       w_accept;
    logic                       w_stage_vld [adm_pkg::QUO_W+1];
    adm_pkg::t_div              w_stage_div [adm_pkg::QUO_W+1];
    adm_pkg::t_div              w_last;
    logic [adm_pkg::QUO_W-1:0]  w_k, w_mag_l, w_mag_r;
    logic [adm_pkg::OUT_W-1:0]  w_ext_l, w_ext_r;
    logic [adm_pkg::OUT_W-1:0]  n_left, n_right;
    logic [adm_pkg::OUT_W-1:0]  r_left, r_right;
    logic                       r_scaled, r_valid;

    assign busy     = ~i_rst_n;
    assign pready   = 1'b1;
    assign w_accept = start & ~busy;

    adm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    adm_mix u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_throttle_cmd (i_throttle_cmd),
        .i_turn_cmd     (i_turn_cmd),
        .i_cfg          (w_cfg),
        .o_valid        (w_stage_vld[0]),
        .o_div          (w_stage_div[0])
    );

    // smaller magnitude times the target, over the peak, one bit per stage
    for (genvar g = 0; g < adm_pkg::QUO_W; g++) begin : g_div
        adm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_stage_vld[g]),
            .i_div   (w_stage_div[g]),
            .o_valid (w_stage_vld[g+1]),
            .o_div   (w_stage_div[g+1])
        );
    end

    assign w_last = w_stage_div[adm_pkg::QUO_W];
    assign w_k    = {w_cfg.throttle_limit, {adm_pkg::K_SHIFT{1'b0}}};

    // when scaled, the peak side lands exactly on the target
    always_comb begin
        w_mag_l = w_last.side.left_min ? w_last.quo : w_k;
        w_mag_r = w_last.side.left_min ? w_k : w_last.quo;
        w_ext_l = {{(adm_pkg::OUT_W-adm_pkg::QUO_W){1'b0}}, w_mag_l};
        w_ext_r = {{(adm_pkg::OUT_W-adm_pkg::QUO_W){1'b0}}, w_mag_r};
        if (w_last.side.scaled) begin
            n_left  = w_last.side.neg_l ? adm_pkg::OUT_W'(0) - w_ext_l : w_ext_l;
            n_right = w_last.side.neg_r ? adm_pkg::OUT_W'(0) - w_ext_r : w_ext_r;
        end else begin
            n_left  = w_last.side.unsc_l;
            n_right = w_last.side.unsc_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_stage_vld[adm_pkg::QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_right  <= n_right;
        r_scaled <= w_last.side.scaled;
    end

    assign o_valid       = r_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_was_scaled  = r_scaled;

`ifndef ASSERT_OFF
    logic [adm_pkg::OUT_W-1:0] w_chk_abs_l, w_chk_abs_r, w_chk_k;

    assign w_chk_abs_l = r_left[adm_pkg::OUT_W-1]  ? adm_pkg::OUT_W'(0) - r_left  : r_left;
    assign w_chk_abs_r = r_right[adm_pkg::OUT_W-1] ? adm_pkg::OUT_W'(0) - r_right : r_right;
    assign w_chk_k     = {{(adm_pkg::OUT_W-adm_pkg::QUO_W){1'b0}}, w_k};

    // every result traces back to a request exactly one pipeline depth earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, adm_pkg::LATENCY))
        else $error("result without a matching request");

    // outputs never exceed throttle_limit, so saturation can never show up here
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_chk_abs_l <= w_chk_k && w_chk_abs_r <= w_chk_k))
        else $error("drive magnitude above throttle limit");

    // normalized results put the peak side exactly on the limit
    a_scaled_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_scaled) |-> (w_chk_abs_l == w_chk_k || w_chk_abs_r == w_chk_k))
        else $error("normalized result misses the limit on both sides");
`endif

endmodule
